FILE: src/biosensor_packet_parser_assert.svh
// Assertion macros used by the packet parser checker
`ifndef BIOSENSOR_PACKET_PARSER_ASSERT_SVH
`define BIOSENSOR_PACKET_PARSER_ASSERT_SVH

// same-cycle implication, off during reset
`define BPP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bpp assertion failed");

// next-cycle implication, off during reset
`define BPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bpp assertion failed");

`endif

FILE: src/bpp_pkg.sv
// Types and constants shared by the biosensor packet parser
`timescale 1ns / 1ps
package bpp_pkg;

    localparam int BYTE_W      = 8;
    localparam int CLIP_W      = 15;
    localparam int SAMPLE_W    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int CAP_DEPTH   = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [7:0]  SYNC_RESET   = 8'd170;
    localparam logic [7:0]  MAXLEN_RESET = 8'd169;
    localparam logic [14:0] CLIP_RESET   = 15'd6000;
    localparam logic [7:0]  LEN_RAW      = 8'd4;
    localparam logic [7:0]  LEN_STATUS   = 8'd18;

    typedef enum logic [1:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        KIND_RAW,
        KIND_STATUS,
        KIND_BADSUM,
        KIND_OTHER
    } kind_t;

    typedef enum logic [1:0] {
        CFG_SYNC,
        CFG_MAXLEN,
        CFG_CLIP
    } cfg_idx_t;

    typedef struct packed {
        kind_t                          kind;
        logic [CAP_DEPTH-1:0][BYTE_W-1:0] bytes;
    } evt_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

FILE: src/bpp_queue.sv
// Two-entry event queue between the byte parser and the result stage
`timescale 1ns / 1ps
module bpp_queue
    import bpp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  evt_t push_evt,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output evt_t head_evt
);

    evt_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_evt  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_evt;
        end
    end

endmodule

FILE: src/bpp_front.sv
// Byte parser: sync hunt, length check, payload capture and checksum classification
`timescale 1ns / 1ps
module bpp_front
    import bpp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BYTE_W-1:0] sync_byte,
    input  logic [BYTE_W-1:0] max_len,
    input  hs_t               in_hs,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              evt_push,
    output evt_t              evt
);

    phase_t                          phase_reg;
    phase_t                          phase_next;
    logic [BYTE_W-1:0]               len_reg;
    logic [BYTE_W-1:0]               idx_reg;
    logic [BYTE_W-1:0]               sum_reg;
    logic [CAP_DEPTH-1:0][BYTE_W-1:0] cap_reg;
    logic                            take;
    logic                            in_payload;
    logic                            at_checksum;

    assign take        = in_hs.valid && in_hs.ready;
    assign in_payload  = (idx_reg < len_reg);
    assign at_checksum = (phase_reg == PH_BODY) && !in_payload;

    // next state
    always_comb begin
        phase_next = phase_reg;
        if (take) begin
            case (phase_reg)
                PH_SYNC1: phase_next = (rx_byte == sync_byte) ? PH_SYNC2 : PH_SYNC1;
                PH_SYNC2: phase_next = (rx_byte == sync_byte) ? PH_LEN : PH_SYNC1;
                PH_LEN:   phase_next = (rx_byte > max_len) ? PH_SYNC1 : PH_BODY;
                PH_BODY:  phase_next = in_payload ? PH_BODY : PH_SYNC1;
                default:  phase_next = PH_SYNC1;
            endcase
        end
    end

    // outputs
    always_comb begin
        evt_push   = take && at_checksum;
        evt.bytes  = cap_reg;
        if (~sum_reg != rx_byte) begin
            evt.kind = KIND_BADSUM;
        end else if (len_reg == LEN_RAW) begin
            evt.kind = KIND_RAW;
        end else if (len_reg == LEN_STATUS) begin
            evt.kind = KIND_STATUS;
        end else begin
            evt.kind = KIND_OTHER;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC1;
            len_reg   <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            if (take && phase_reg == PH_LEN && rx_byte <= max_len) begin
                len_reg <= rx_byte;
                idx_reg <= '0;
                sum_reg <= '0;
            end else if (take && phase_reg == PH_BODY) begin
                if (in_payload) begin
                    idx_reg <= idx_reg + 1'b1;
                    sum_reg <= sum_reg + rx_byte;
                end else begin
                    idx_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && phase_reg == PH_BODY && in_payload && idx_reg < BYTE_W'(CAP_DEPTH)) begin
            cap_reg[idx_reg[1:0]] <= rx_byte;
        end
    end

endmodule

FILE: src/bpp_back.sv
// Result stage: sample decode, clipping, level and heart rate update, output register
`timescale 1ns / 1ps
module bpp_back
    import bpp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CLIP_W-1:0]   clip_limit,
    input  logic                evt_valid,
    input  evt_t                evt,
    output logic                evt_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output kind_t               out_kind,
    output logic [SAMPLE_W-1:0] out_sample,
    output logic [BYTE_W-1:0]   out_level,
    output logic [BYTE_W-1:0]   out_hr
);

    logic                out_valid_reg;
    kind_t               kind_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] sample_next;
    logic [BYTE_W-1:0]   level_reg;
    logic [BYTE_W-1:0]   level_next;
    logic [BYTE_W-1:0]   hr_reg;
    logic [BYTE_W-1:0]   hr_next;
    logic [BYTE_W-1:0]   hi_byte;
    logic [BYTE_W-1:0]   lo_byte;
    logic [SAMPLE_W-1:0] word;
    logic [SAMPLE_W:0]   mag;

    assign evt_pop = evt_valid && (!out_valid_reg || out_ready);

    always_comb begin
        hi_byte = evt.bytes[0][7] ? evt.bytes[2] : evt.bytes[1];
        lo_byte = evt.bytes[0][7] ? evt.bytes[3] : evt.bytes[2];
        word    = {hi_byte, lo_byte};
        mag     = word[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {word[SAMPLE_W-1], word})
                                   : {1'b0, word};
        sample_next = '0;
        level_next  = level_reg;
        hr_next     = hr_reg;
        case (evt.kind)
            KIND_RAW: begin
                if (level_reg != '0 && mag <= {2'b00, clip_limit}) begin
                    sample_next = word;
                end
            end
            KIND_STATUS: begin
                level_next = evt.bytes[1];
                hr_next    = (evt.bytes[1] != '0) ? evt.bytes[3] : '0;
            end
            default: begin
                sample_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            level_reg     <= 8'd1;
            hr_reg        <= '0;
        end else begin
            if (evt_pop) begin
                out_valid_reg <= 1'b1;
                level_reg     <= level_next;
                hr_reg        <= hr_next;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (evt_pop) begin
            kind_reg   <= evt.kind;
            sample_reg <= sample_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = kind_reg;
    assign out_sample = sample_reg;
    assign out_level  = level_reg;
    assign out_hr     = hr_reg;

endmodule

FILE: src/biosensor_packet_parser.sv
// Top level of the biosensor serial packet parser
// Throughput: one byte per cycle, sustained while the result side keeps up.
// A checksum byte's event is written to the event queue, then moved to the result register once that is free.
// The two-entry event queue lets the byte side run on while a result waits.
// Reset: synchronous active-low aresetn restores register defaults, sync hunt,
// signal level 1 and heart rate 0; no clearing pass is needed.
`timescale 1ns / 1ps
module biosensor_packet_parser
    import bpp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,    // [15:0] raw_sample, [23:16] signal_quality,
                                              // [31:24] heart_rate_value
    output logic [1:0]            m_tuser,    // [1:0] packet_kind
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [BYTE_W-1:0]   sync_reg;
    logic [BYTE_W-1:0]   maxlen_reg;
    logic [CLIP_W-1:0]   clip_reg;
    hs_t                 in_hs;
    logic                evt_push;
    evt_t                push_evt;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    evt_t                head_evt;
    kind_t               out_kind;
    logic [SAMPLE_W-1:0] out_sample;
    logic [BYTE_W-1:0]   out_level;
    logic [BYTE_W-1:0]   out_hr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg   <= SYNC_RESET;
            maxlen_reg <= MAXLEN_RESET;
            clip_reg   <= CLIP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SYNC:   sync_reg   <= cfg_data[BYTE_W-1:0];
                CFG_MAXLEN: maxlen_reg <= cfg_data[BYTE_W-1:0];
                CFG_CLIP:   clip_reg   <= cfg_data[CLIP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready    = !q_full;
    assign in_hs.valid = s_tvalid;
    assign in_hs.ready = s_tready;

    bpp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sync_byte (sync_reg),
        .max_len   (maxlen_reg),
        .in_hs     (in_hs),
        .rx_byte   (s_tdata),
        .evt_push  (evt_push),
        .evt       (push_evt)
    );

    bpp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (evt_push),
        .push_evt  (push_evt),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_evt  (head_evt)
    );

    bpp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clip_limit (clip_reg),
        .evt_valid  (q_valid),
        .evt        (head_evt),
        .evt_pop    (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (out_kind),
        .out_sample (out_sample),
        .out_level  (out_level),
        .out_hr     (out_hr)
    );

    assign m_tdata = {out_hr, out_level, out_sample};
    assign m_tuser = out_kind;

endmodule

FILE: src/bpp_checker.sv
// Port-level checker for the packet parser, bound to the top level
`timescale 1ns / 1ps
`include "biosensor_packet_parser_assert.svh"
module bpp_checker
    import bpp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `BPP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `BPP_ASSERT_IMPL(a_sample_only_raw, aclk, aresetn, m_tvalid && m_tuser != KIND_RAW, m_tdata[15:0] == 16'd0)
    `BPP_ASSERT_IMPL(a_no_signal_no_sample, aclk, aresetn, m_tvalid && m_tdata[23:16] == 8'd0, m_tdata[15:0] == 16'd0)
    `BPP_ASSERT_IMPL(a_no_signal_no_hr, aclk, aresetn, m_tvalid && m_tuser == KIND_STATUS && m_tdata[23:16] == 8'd0, m_tdata[31:24] == 8'd0)

endmodule

bind biosensor_packet_parser bpp_checker u_bpp_checker (.*);

FILE: dv/biosensor_packet_parser_tb.sv
// Self-checking testbench for the biosensor packet parser: framed byte stream in, parsed results out
`timescale 1ns / 1ps
module biosensor_packet_parser_tb;
    import bpp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned BYTES_PER_SETUP = 90;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] sample;
        logic [7:0]  level;
        logic [7:0]  rate;
    } parse_result_t;

    class packet_scoreboard;
        logic [7:0]    sync_val;
        logic [7:0]    len_limit;
        logic [14:0]   clip_limit;
        phase_t        phase;
        logic [7:0]    body_len;
        logic [7:0]    body_idx;
        logic [7:0]    body_sum;
        logic [7:0]    cap [4];
        logic [7:0]    level;
        logic [7:0]    rate;
        parse_result_t expected_q [$];
        int            errors;

        function new();
            errors = 0;
            sync_val = SYNC_RESET;
            len_limit = MAXLEN_RESET;
            clip_limit = CLIP_RESET;
            phase = PH_SYNC1;
            body_len = 8'd0;
            body_idx = 8'd0;
            body_sum = 8'd0;
            foreach (cap[i]) cap[i] = 8'd0;
            level = 8'd1;
            rate = 8'd0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SYNC: sync_val = data[7:0];
                CFG_MAXLEN: len_limit = data[7:0];
                CFG_CLIP: clip_limit = data[14:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] decode_sample();
            int          pos;
            logic [15:0] word;
            int          s;
            int          mag;
            pos = cap[0][7] ? 2 : 1;
            word = {cap[pos], cap[(pos + 1) % 4]};
            s = $signed(word);
            mag = (s < 0) ? -s : s;
            if (level == 8'd0 || mag > int'(clip_limit))
                return 16'h0000;
            return word;
        endfunction

        function void note_byte(logic [7:0] b);
            parse_result_t r;
            case (phase)
                PH_SYNC1: begin
                    if (b == sync_val)
                        phase = PH_SYNC2;
                end
                PH_SYNC2: begin
                    phase = (b == sync_val) ? PH_LEN : PH_SYNC1;
                end
                PH_LEN: begin
                    if (b > len_limit) begin
                        phase = PH_SYNC1;
                    end else begin
                        body_len = b;
                        body_idx = 8'd0;
                        body_sum = 8'd0;
                        phase = PH_BODY;
                    end
                end
                default: begin
                    if (body_idx < body_len) begin
                        if (body_idx < 8'd4)
                            cap[body_idx[1:0]] = b;
                        body_sum = body_sum + b;
                        body_idx = body_idx + 8'd1;
                    end else begin
                        // checksum byte closes the packet
                        phase = PH_SYNC1;
                        body_idx = 8'd0;
                        r.sample = 16'h0000;
                        if (~body_sum != b) begin
                            r.kind = KIND_BADSUM;
                        end else if (body_len == LEN_RAW) begin
                            r.kind = KIND_RAW;
                            r.sample = decode_sample();
                        end else if (body_len == LEN_STATUS) begin
                            r.kind = KIND_STATUS;
                            level = cap[1];
                            rate = (level != 8'd0) ? cap[3] : 8'd0;
                        end else begin
                            r.kind = KIND_OTHER;
                        end
                        r.level = level;
                        r.rate = rate;
                        expected_q.push_back(r);
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
            if (exp_val !== act_val) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, name, exp_val, act_val);
            end
        endfunction

        function void check_result(logic [1:0] kind_bits, logic [31:0] data);
            parse_result_t e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual kind %0d data %h",
                         $time, kind_bits, data);
                return;
            end
            e = expected_q.pop_front();
            compare_field("packet_kind", 16'(e.kind), 16'(kind_bits));
            compare_field("raw_sample", e.sample, data[15:0]);
            compare_field("signal_quality", 16'(e.level), 16'(data[23:16]));
            compare_field("heart_rate_value", 16'(e.rate), 16'(data[31:24]));
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;    // [7:0] rx_byte
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;    // [15:0] raw_sample, [23:16] signal_quality,
                                       // [31:24] heart_rate_value
    logic [1:0]            m_tuser;    // [1:0] packet_kind
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    packet_scoreboard sb;
    int unsigned      src_idle_pct;
    int unsigned      sink_stall_pct;
    int unsigned      bytes_sent;
    int unsigned      cycle_count;
    logic [7:0]       frame_body [$];

    biosensor_packet_parser u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] len, input bit bad_sum);
        logic [7:0] sum;
        sum = 8'd0;
        send_byte(sb.sync_val);
        send_byte(sb.sync_val);
        send_byte(len);
        foreach (frame_body[i]) begin
            send_byte(frame_body[i]);
            sum = sum + frame_body[i];
        end
        send_byte(bad_sum ? (~sum ^ 8'($urandom_range(1, 255))) : ~sum);
    endtask

    task automatic fill_raw(input bit alt_pos, input logic [15:0] word);
        logic [7:0] code;
        code = 8'($urandom);
        code[7] = alt_pos;
        frame_body.delete();
        frame_body.push_back(code);
        if (alt_pos) begin
            frame_body.push_back(8'($urandom));
            frame_body.push_back(word[15:8]);
            frame_body.push_back(word[7:0]);
        end else begin
            frame_body.push_back(word[15:8]);
            frame_body.push_back(word[7:0]);
            frame_body.push_back(8'($urandom));
        end
    endtask

    task automatic fill_status(input logic [7:0] lvl, input logic [7:0] hr_val);
        frame_body.delete();
        repeat (18) frame_body.push_back(8'($urandom));
        frame_body[1] = lvl;
        frame_body[3] = hr_val;
    endtask

    task automatic fill_random(input int n);
        frame_body.delete();
        repeat (n) frame_body.push_back(8'($urandom));
    endtask

    // samples around the clip limit, the extremes, and anything
    function automatic logic [15:0] pick_sample();
        int c;
        int v;
        c = sb.clip_limit;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, c);
            1: v = c + 1;
            2: v = c;
            3: v = -32768;
            4: v = 32767;
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 1) && v != -32768)
            v = -v;
        return v[15:0];
    endfunction

    task automatic random_frame();
        int r;
        int n;
        int top;
        bit bad;
        r = $urandom_range(0, 99);
        bad = ($urandom_range(0, 99) < 12);
        if (r < 8) begin
            // noise and broken sync
            if ($urandom_range(0, 1))
                send_byte(sb.sync_val);
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end else if (r < 13 && sb.len_limit != 8'hFF) begin
            send_byte(sb.sync_val);
            send_byte(sb.sync_val);
            send_byte(8'($urandom_range(int'(sb.len_limit) + 1, 255)));
        end else if (r < 50 && sb.len_limit >= LEN_RAW) begin
            fill_raw($urandom_range(0, 1), pick_sample());
            send_frame(LEN_RAW, bad);
        end else if (r < 75 && sb.len_limit >= LEN_STATUS) begin
            fill_status(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom), 8'($urandom));
            send_frame(LEN_STATUS, bad);
        end else begin
            top = (sb.len_limit < 8'd24) ? int'(sb.len_limit) : 24;
            if ($urandom_range(0, 99) < 3)
                n = $urandom_range(0, int'(sb.len_limit));
            else
                n = $urandom_range(0, top);
            fill_random(n);
            send_frame(8'(n), bad);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // drain all results, then give in-flight bytes time to retire
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned start;
        sb = new();
        cycle_count = 0;
        bytes_sent = 0;
        src_idle_pct = 30;
        sink_stall_pct = 87;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SYNC;
        cfg_data = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed packets at reset settings
        fill_raw(1'b0, 16'h1234);
        send_frame(LEN_RAW, 1'b0);
        fill_raw(1'b1, 16'hFE0C);
        send_frame(LEN_RAW, 1'b0);
        fill_raw(1'b0, 16'h7FFF);
        send_frame(LEN_RAW, 1'b0);
        fill_raw(1'b1, 16'h8000);
        send_frame(LEN_RAW, 1'b0);
        fill_raw(1'b0, 16'd6000);
        send_frame(LEN_RAW, 1'b0);
        fill_raw(1'b1, -16'sd6001);
        send_frame(LEN_RAW, 1'b0);
        fill_status(8'd0, 8'd77);
        send_frame(LEN_STATUS, 1'b0);
        fill_raw(1'b0, 16'h0100);
        send_frame(LEN_RAW, 1'b0);
        fill_status(8'd200, 8'd72);
        send_frame(LEN_STATUS, 1'b0);
        fill_raw(1'b0, 16'h0042);
        send_frame(LEN_RAW, 1'b1);
        fill_random(0);
        send_frame(8'd0, 1'b0);
        send_byte(SYNC_RESET);
        send_byte(SYNC_RESET);
        send_byte(MAXLEN_RESET + 8'd1);
        send_byte(SYNC_RESET);
        send_byte(8'h55);
        send_byte(SYNC_RESET);
        send_byte(SYNC_RESET);
        send_byte(SYNC_RESET);
        fill_random(5);
        send_frame(8'd5, 1'b0);
        fill_random(int'(MAXLEN_RESET));
        send_frame(MAXLEN_RESET, 1'b0);

        for (int setup = 0; setup < 6; setup++) begin
            settle();
            src_idle_pct = (setup < 2) ? 30 : (setup < 4) ? 87 : 0;
            sink_stall_pct = (setup < 2) ? 87 : (setup < 4) ? 30 : 0;
            case (setup)
                0: begin
                    write_reg(CFG_SPARE, 15'($urandom));
                    write_reg(CFG_SYNC, 15'h00AA);
                    write_reg(CFG_MAXLEN, 15'd169);
                    write_reg(CFG_CLIP, 15'd6000);
                end
                1: begin
                    write_reg(CFG_SYNC, 15'h0000);
                    write_reg(CFG_MAXLEN, 15'd255);
                    write_reg(CFG_CLIP, 15'h7FFF);
                end
                2: begin
                    write_reg(CFG_SYNC, 15'h7FFF);
                    write_reg(CFG_MAXLEN, 15'd20);
                    write_reg(CFG_CLIP, 15'd0);
                end
                3: begin
                    write_reg(CFG_SYNC, 15'h005A);
                    write_reg(CFG_MAXLEN, 15'd0);
                    write_reg(CFG_CLIP, 15'd100);
                    write_reg(CFG_SPARE, 15'($urandom));
                end
                4: begin
                    write_reg(CFG_SYNC, 15'($urandom_range(0, 255)));
                    write_reg(CFG_MAXLEN, 15'd18);
                    write_reg(CFG_CLIP, 15'($urandom_range(0, 32767)));
                end
                default: begin
                    write_reg(CFG_SYNC, 15'h2AAA);
                    write_reg(CFG_MAXLEN, 15'd4);
                    write_reg(CFG_CLIP, 15'h7FFF);
                end
            endcase
            start = bytes_sent;
            while (bytes_sent - start < BYTES_PER_SETUP) random_frame();
        end

        settle();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
